@@ sv/signature_dedup_id_assigner_macros.svh @@
// assertion macros for the signature dedup block
`ifndef SIGNATURE_DEDUP_ID_ASSIGNER_MACROS_SVH
`define SIGNATURE_DEDUP_ID_ASSIGNER_MACROS_SVH

// property that must hold on every clock outside reset
`define SDA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on a clock outside reset
`define SDA_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/sda_pkg.sv @@
//------------------------------------------------------------------------------
// sda_pkg
// shared types and constants for the signature dedup id assigner
//------------------------------------------------------------------------------
package sda_pkg;

	localparam int unsigned MAX_UNIQUE_DEF  = 256;
	localparam int unsigned MAX_SIG_LEN_DEF = 64;
	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ELEM  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] base_value;
		logic       last_element;
	} req_t;

	typedef struct packed {
		logic [7:0] sig_id;
		logic       is_new;
		logic [1:0] status;
	} rsp_t;

endpackage

@@ sv/sda_ram.sv @@
//------------------------------------------------------------------------------
// sda_ram
// generic single port ram with registered read
//------------------------------------------------------------------------------
module sda_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// registered read, returns the old data on a write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ sv/sda_cell.sv @@
//------------------------------------------------------------------------------
// sda_cell
// one cell of the gather chain: holds one byte and passes it on when shifting
//------------------------------------------------------------------------------
module sda_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] dout
);
	logic [7:0] byte_q;

	// byte moves one cell down the chain on shift
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end
	assign dout = byte_q;
endmodule

@@ sv/signature_dedup_id_assigner.sv @@
//------------------------------------------------------------------------------
// signature_dedup_id_assigner
// assigns first-appearance ids to byte signatures, hash filtered table lookup
//------------------------------------------------------------------------------
// usage: requests arrive on req (valid/stall). kind clear empties the table,
// kind element adds a byte (last_element ends the signature), kind empty gives
// id 0 at once. one response per finished or empty signature on rsp.
// flow: a byte without last marker leaves the block idle, so bytes can stream
// back to back while no response waits. an empty signature answers the cycle
// after it is taken, an overlong one after passing through S_OUT. a finished
// signature then walks the table entry by entry: each candidate has its hash
// and length read (S_HRD, S_HCHK), a hash and length hit compares the bytes
// one at a time through the single port store (S_BRD, S_BCHK), a new entry is
// written back one byte at a time from the gather chain (S_WR), and S_OUT
// loads the response. one request is in work at a time.
// reset: table empty, running hash at the fnv basis; no clearing pass is
// needed since only entries below the count are read.
// stall on rsp: the response register holds its value and req stays stalled
// until the response has been taken.
//------------------------------------------------------------------------------
module signature_dedup_id_assigner #(
	parameter int unsigned MAX_UNIQUE  = sda_pkg::MAX_UNIQUE_DEF,
	parameter int unsigned MAX_SIG_LEN = sda_pkg::MAX_SIG_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sda_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sda_pkg::rsp_t rsp
);
	import sda_pkg::*;

	localparam int unsigned EW = $clog2(MAX_UNIQUE);
	localparam int unsigned CW = $clog2(MAX_UNIQUE + 1);
	localparam int unsigned LW = $clog2(MAX_SIG_LEN + 1);
	localparam int unsigned BW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
	localparam int unsigned SW = $clog2(MAX_UNIQUE * MAX_SIG_LEN);
	localparam int unsigned IDW = (EW < 8) ? EW : 8;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_HRD   = 7'b0000010,
		S_HCHK  = 7'b0000100,
		S_BRD   = 7'b0001000,
		S_BCHK  = 7'b0010000,
		S_WR    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [31:0]       hash_q;
	logic [LW-1:0]     len_q;
	logic              over_q;
	logic [CW-1:0]     idx_q;
	logic [LW-1:0]     pos_q;
	logic              match_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// gather chain: cell 0 is the newest byte; rotating the first len cells
	// keeps the byte order
	logic [7:0] chain [MAX_SIG_LEN];
	logic [7:0] chain_in [MAX_SIG_LEN];
	logic [7:0] head_byte;
	logic       shift;
	logic       rot;
	logic       accept;
	logic [31:0] hash_next;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign shift = (accept && req.kind == KIND_ELEM && len_q < LW'(MAX_SIG_LEN)) || rot;

	genvar g;
	generate
		for (g = 0; g < int'(MAX_SIG_LEN); g++) begin : g_cell
			if (g == 0) begin : g_first
				assign chain_in[g] = rot ? head_byte : req.base_value;
			end else begin : g_rest
				assign chain_in[g] = chain[g-1];
			end
			sda_cell u_cell (.clk(clk), .shift(shift), .din(chain_in[g]), .dout(chain[g]));
		end
	endgenerate

	// oldest byte sits at cell len-1; each rotation brings the next byte there
	assign head_byte = chain[BW'(len_q - LW'(1))];

	// hash and length tables, signature store
	logic          hl_we;
	logic [EW-1:0] hl_addr;
	logic [31:0]   eh_rd;
	logic [LW-1:0] el_rd;
	logic          st_we;
	logic [SW-1:0] st_addr;
	logic [7:0]    st_rd;

	assign hl_addr = EW'(idx_q);
	assign hl_we   = (state_q == S_WR) && (pos_q == '0);
	assign st_we   = (state_q == S_WR);
	assign st_addr = SW'(idx_q) * SW'(MAX_SIG_LEN) + SW'(pos_q);

	sda_ram #(.WIDTH(32), .DEPTH(MAX_UNIQUE)) u_hash (
		.clk(clk), .we(hl_we), .addr(hl_addr), .wdata(hash_q), .rdata(eh_rd));
	sda_ram #(.WIDTH(LW), .DEPTH(MAX_UNIQUE)) u_len (
		.clk(clk), .we(hl_we), .addr(hl_addr), .wdata(len_q), .rdata(el_rd));
	sda_ram #(.WIDTH(8), .DEPTH(MAX_UNIQUE * MAX_SIG_LEN)) u_store (
		.clk(clk), .we(st_we), .addr(st_addr), .wdata(head_byte), .rdata(st_rd));

	// rotate once per byte during compare check and write
	assign rot = (state_q == S_BCHK) || (state_q == S_WR);

	assign hash_next = (hash_q ^ {24'd0, req.base_value}) * HASH_PRIME;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hash_q      <= HASH_BASIS;
			len_q       <= '0;
			over_q      <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			match_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.kind)
							KIND_CLEAR: begin
								count_q <= '0;
								hash_q  <= HASH_BASIS;
								len_q   <= '0;
								over_q  <= 1'b0;
							end
							KIND_EMPTY: begin
								hash_q      <= HASH_BASIS;
								len_q       <= '0;
								over_q      <= 1'b0;
								rsp_q       <= '{sig_id: '0, is_new: 1'b0, status: ST_OK};
								rsp_valid_q <= 1'b1;
							end
							KIND_ELEM: begin
								if (len_q < LW'(MAX_SIG_LEN)) begin
									hash_q <= hash_next;
									len_q  <= len_q + LW'(1);
								end else begin
									over_q <= 1'b1;
								end
								if (req.last_element) begin
									idx_q <= '0;
									if (over_q || len_q >= LW'(MAX_SIG_LEN)) begin
										state_q <= S_OUT;
										rsp_q   <= '{sig_id: '0, is_new: 1'b0,
											status: ST_TOO_LONG};
									end else begin
										state_q <= S_HRD;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_HRD: begin
					if (idx_q >= count_q) begin
						if (count_q >= CW'(MAX_UNIQUE)) begin
							rsp_q   <= '{sig_id: '0, is_new: 1'b0, status: ST_FULL};
							state_q <= S_OUT;
						end else begin
							pos_q   <= '0;
							state_q <= S_WR;
						end
					end else begin
						state_q <= S_HCHK;
					end
				end
				S_HCHK: begin
					if (eh_rd == hash_q && el_rd == len_q) begin
						pos_q   <= '0;
						match_q <= 1'b1;
						state_q <= S_BRD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_HRD;
					end
				end
				S_BRD: begin
					if (pos_q == len_q) begin
						// finished pass; len rotations bring the chain back in order
						if (match_q) begin
							rsp_q   <= '{sig_id: 8'(IDW'(idx_q)), is_new: 1'b0,
								status: ST_OK};
							state_q <= S_OUT;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_HRD;
						end
					end else begin
						state_q <= S_BCHK;
					end
				end
				S_BCHK: begin
					if (st_rd != head_byte) begin
						match_q <= 1'b0;
					end
					pos_q   <= pos_q + LW'(1);
					state_q <= S_BRD;
				end
				S_WR: begin
					pos_q <= pos_q + LW'(1);
					if (pos_q + LW'(1) >= len_q) begin
						rsp_q   <= '{sig_id: 8'(IDW'(idx_q)), is_new: 1'b1,
							status: ST_OK};
						count_q <= count_q + CW'(1);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					hash_q      <= HASH_BASIS;
					len_q       <= '0;
					over_q      <= 1'b0;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ sv/sda_checker.sv @@
//------------------------------------------------------------------------------
// sda_checker
// port level checks for the signature dedup id assigner
//------------------------------------------------------------------------------
`include "signature_dedup_id_assigner_macros.svh"

module sda_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input sda_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sda_pkg::rsp_t rsp
);
	import sda_pkg::*;

	// held response keeps its payload
	`SDA_ASSERT(a_rsp_hold, clk, arst_n,
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp dropped")
	// an empty signature answers next cycle with id zero
	`SDA_ASSERT(a_empty, clk, arst_n,
		req_valid && !req_stall && req.kind == KIND_EMPTY |=> rsp_valid && rsp.sig_id == 8'd0,
		"empty rsp")
	// an error status never marks new
	`SDA_ASSERT(a_err_new, clk, arst_n,
		rsp_valid && rsp.status != ST_OK |-> !rsp.is_new && rsp.sig_id == 8'd0, "error rsp")
	// no request is taken while a response waits
	`SDA_NEVER(a_req_blocked, clk, arst_n,
		req_valid && !req_stall && rsp_valid, "req taken with rsp pending")
endmodule

bind signature_dedup_id_assigner sda_checker u_sda_checker (.*);

@@ sim/signature_dedup_id_assigner_test.sv @@
//------------------------------------------------------------------------------
// signature_dedup_id_assigner_test
// drives byte signatures, empties and clears into the dedup block and checks
// every response against a behavioral table kept in the testbench
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module signature_dedup_id_assigner_test;
	import sda_pkg::*;

	localparam int unsigned TABLE_DEPTH = MAX_UNIQUE_DEF;
	localparam int unsigned SIG_LIMIT   = MAX_SIG_LEN_DEF;
	localparam longint CYCLE_LIMIT      = 5000000;

	// dedup table mirror and expected response queue
	class dedup_scoreboard;
		logic [7:0]  entry_bytes [TABLE_DEPTH][SIG_LIMIT];
		logic [31:0] entry_hash [TABLE_DEPTH];
		int          entry_len [TABLE_DEPTH];
		int          entry_count;
		logic [7:0]  gather [SIG_LIMIT];
		logic [31:0] run_hash;
		int          run_len;
		bit          overlong;
		rsp_t        pending [$];
		int          errors;
		int          checked;
		int          new_ids;
		int          full_hits;
		int          long_hits;

		function new();
			entry_count = 0;
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			run_hash = HASH_BASIS;
			run_len  = 0;
			overlong = 0;
		endfunction

		function int lookup();
			bit same;
			for (int i = 0; i < entry_count; i++) begin
				if (entry_hash[i] == run_hash && entry_len[i] == run_len) begin
					same = 1;
					for (int j = 0; j < run_len; j++)
						if (entry_bytes[i][j] != gather[j]) same = 0;
					if (same) return i;
				end
			end
			return entry_count;
		endfunction

		// note one accepted request
		function void note_request(req_t r);
			rsp_t e;
			int idx;
			if (r.kind == KIND_CLEAR) begin
				entry_count = 0;
				restart();
				return;
			end
			if (r.kind == KIND_EMPTY) begin
				restart();
				e = '{sig_id: 8'd0, is_new: 1'b0, status: ST_OK};
				pending.insert(pending.size(), e);
				return;
			end
			if (r.kind != KIND_ELEM) return;
			if (run_len < SIG_LIMIT) begin
				gather[run_len] = r.base_value;
				run_len++;
				run_hash = (run_hash ^ {24'd0, r.base_value}) * HASH_PRIME;
			end else
				overlong = 1;
			if (!r.last_element) return;
			if (overlong) begin
				e = '{sig_id: 8'd0, is_new: 1'b0, status: ST_TOO_LONG};
				long_hits++;
			end else begin
				idx = lookup();
				if (idx < entry_count)
					e = '{sig_id: idx[7:0], is_new: 1'b0, status: ST_OK};
				else if (entry_count >= TABLE_DEPTH) begin
					e = '{sig_id: 8'd0, is_new: 1'b0, status: ST_FULL};
					full_hits++;
				end else begin
					for (int j = 0; j < run_len; j++) entry_bytes[entry_count][j] = gather[j];
					entry_hash[entry_count] = run_hash;
					entry_len[entry_count] = run_len;
					e = '{sig_id: entry_count[7:0], is_new: 1'b1, status: ST_OK};
					entry_count++;
					new_ids++;
				end
			end
			pending.insert(pending.size(), e);
			restart();
		endfunction

		// compare one response with the oldest expectation
		task check_response(rsp_t got);
			rsp_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing expected", got, got);
				return;
			end
			e = pending.pop_front();
			if (got.sig_id !== e.sig_id)
				report_mismatch("sig_id", got, e);
			if (got.is_new !== e.is_new)
				report_mismatch("is_new", got, e);
			if (got.status !== e.status)
				report_mismatch("status", got, e);
		endtask

		task report_mismatch(string what, rsp_t got, rsp_t want);
			errors++;
			if (errors <= 40)
				$display("error: %s got id=%0d new=%0b st=%0d want id=%0d new=%0b st=%0d",
					what, got.sig_id, got.is_new, got.status,
					want.sig_id, want.is_new, want.status);
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	dedup_scoreboard board;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    sent_count;
	bit    hold_off;
	longint cycle_count;
	logic [7:0] pool [16][SIG_LIMIT];
	int    pool_len [16];

	signature_dedup_id_assigner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// cycle limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("signature_dedup_id_assigner: mismatch");
			$finish;
		end
	end

	// response side: random stall, long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) board.check_response(rsp);
			rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// send one request, idling at random first; valid stays up until the next
	// request or an explicit stop
	task automatic send_request(input logic [1:0] kind, input logic [7:0] b,
			input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind: kind, base_value: b, last_element: lst};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(req);
		sent_count++;
	endtask

	task automatic stop_sending();
		req_valid <= 1'b0;
	endtask

	task automatic send_signature(input int which, input int len);
		for (int i = 0; i < len; i++)
			send_request(KIND_ELEM, pool[which][i % SIG_LIMIT], i == len - 1);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (2 * SIG_LIMIT + 20) @(posedge clk);
	endtask

	// one random item: mostly whole signatures from a small pool
	task automatic random_item();
		int r;
		int w;
		r = $urandom_range(99);
		w = $urandom_range(15);
		if (r < 70)
			send_signature(w, pool_len[w]);
		else if (r < 78)
			send_signature(w, $urandom_range(1, SIG_LIMIT));
		else if (r < 82)
			send_signature(w, $urandom_range(SIG_LIMIT + 1, SIG_LIMIT + 6));
		else if (r < 87)
			send_request(KIND_EMPTY, 8'($urandom), 1'($urandom));
		else if (r < 89)
			send_request(KIND_CLEAR, 8'($urandom), 1'($urandom));
		else if (r < 91)
			send_request(2'd3, 8'($urandom), 1'($urandom));
		else if (r < 96)
			send_request(KIND_ELEM, 8'($urandom), 1'b1);
		else begin
			// partial signature dropped by an empty
			send_request(KIND_ELEM, 8'($urandom), 1'b0);
			send_request(KIND_EMPTY, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic random_phase(input int sidle, input int ridle, input int quota);
		int goal;
		goal = sent_count + quota;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		while (sent_count < goal) random_item();
		stop_sending();
	endtask

	initial begin
		board = new();
		arst_n = 0;
		req_valid = 0;
		req = '0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_count = 0;
		for (int p = 0; p < 16; p++) begin
			pool_len[p] = (p < 12) ? $urandom_range(1, 8) : $urandom_range(1, SIG_LIMIT);
			for (int j = 0; j < SIG_LIMIT; j++) pool[p][j] = 8'($urandom);
		end
		pool[0][0] = 8'h00;
		pool[1][0] = 8'hff;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every kind, overlong, exact max length
		send_request(KIND_EMPTY, 8'hff, 1'b1);
		send_request(KIND_ELEM, 8'h00, 1'b1);
		send_request(KIND_ELEM, 8'hff, 1'b1);
		send_request(KIND_ELEM, 8'h00, 1'b1);
		send_request(KIND_ELEM, 8'h55, 1'b0);
		send_request(KIND_EMPTY, 8'haa, 1'b0);
		send_request(2'd3, 8'hff, 1'b1);
		send_signature(15, SIG_LIMIT);
		send_signature(15, SIG_LIMIT + 1);
		send_signature(15, SIG_LIMIT);
		send_request(KIND_ELEM, 8'h12, 1'b0);
		send_request(KIND_CLEAR, 8'hff, 1'b1);
		send_request(KIND_ELEM, 8'hff, 1'b1);
		stop_sending();
		drain();

		// fill the table: 256 distinct two-byte signatures then one more
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			send_request(KIND_ELEM, k[7:0], 1'b0);
			send_request(KIND_ELEM, k[8] ? 8'h5a : 8'ha5, 1'b1);
		end
		send_request(KIND_ELEM, 8'h07, 1'b0);
		send_request(KIND_ELEM, 8'ha5, 1'b1);
		send_request(KIND_CLEAR, 8'h00, 1'b0);

		// long receiver hold-off while requests keep coming
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int n = 0; n < 40; n++) send_request(KIND_ELEM, 8'($urandom), 1'b1);
				stop_sending();
			end
		join
		drain();

		random_phase(29, 50, 280);
		drain();
		random_phase(50, 29, 280);
		drain();
		random_phase(0, 0, 280);
		drain();

		$display("covered %0d requests, %0d responses: %0d new ids, %0d table full, %0d overlong",
			sent_count, board.checked, board.new_ids, board.full_hits, board.long_hits);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("signature_dedup_id_assigner: match");
		else
			$display("signature_dedup_id_assigner: mismatch");
		$finish;
	end
endmodule
